// File: design/zbuffered_line_rasterizer_defines.svh
// Assertion macros shared by the rasterizer modules.
`ifndef ZBUFFERED_LINE_RASTERIZER_DEFINES_SVH
`define ZBUFFERED_LINE_RASTERIZER_DEFINES_SVH
`ifndef SYNTH
`define ZLR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ZLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ZLR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ZLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/zlr_pkg.sv
// Shared types and constants of the line rasterizer.
package zlr_pkg;
    localparam int COORD_W = 6;
    localparam int DEPTH_W = 24;
    localparam int COLOR_W = 24;
    localparam int SHADE_W = 16;
    localparam int ACC_W   = 40;
    localparam int FRAC_W  = 15;
    localparam int DIFF_W  = DEPTH_W + 1 + FRAC_W;
    localparam logic signed [DEPTH_W-1:0] CLEAR_DEPTH_RST = -24'sd2560000;
    localparam logic ADDR_CLEAR_DEPTH = 1'b0;

    typedef struct packed {
        logic load;      // latch request, start setup
        logic div_start;
        logic div_step;
        logic div_done;  // latch quotient
        logic clr_step;
        logic rd;        // read store at current pixel
        logic wr;        // compare, emit, write, advance
    } t_cmd;

    typedef struct packed {
        logic single;
        logic div_last;
        logic clr_last;
        logic last_pix;
    } t_sts;
endpackage

// File: design/zlr_ctrl.sv
// Sequencer of the line rasterizer.
`include "zbuffered_line_rasterizer_defines.svh"
module zlr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_clear_first,
    input  logic          i_out_ready,
    input  zlr_pkg::t_sts i_sts,
    output logic          o_ready,
    output logic          o_out_valid,
    output zlr_pkg::t_cmd o_cmd
);
    import zlr_pkg::*;
    typedef enum logic [2:0] {S_CLR, S_IDLE, S_DIV, S_RD, S_EMIT} t_state;
    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic r_clr_pend, n_clr_pend;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        n_clr_pend = r_clr_pend;
        o_cmd = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_pend ? S_DIV : S_IDLE;
                    if (r_clr_pend) o_cmd.div_start = 1'b1;
                    n_clr_pend = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_clear_first) begin
                        n_state = S_CLR;
                        n_clr_pend = 1'b1;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.single) begin
                    n_state = S_RD;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.div_last) begin
                        o_cmd.div_done = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_EMIT;
                end
                if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
            end
            S_EMIT: begin
                o_cmd.wr = 1'b1;
                n_out_valid = 1'b1;
                n_state = i_sts.last_pix ? S_IDLE : S_RD;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state != S_RD && r_state != S_EMIT && r_out_valid && i_out_ready)
            n_out_valid = 1'b0;
        // start-of-load clear lives in datapath; div_start issued on load when no clear
        if (r_state == S_IDLE && i_valid && !i_clear_first) o_cmd.div_start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_out_valid <= 1'b0;
            r_clr_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_clr_pend <= n_clr_pend;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `ZLR_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.wr, o_cmd.rd, o_cmd.clr_step}))
    `ZLR_ASSERT_IMPL(a_wr_free, i_clk, i_rst_n, o_cmd.wr, !r_out_valid || $past(i_out_ready))
    `ZLR_ASSERT_NEXT(a_rd_wr, i_clk, i_rst_n, o_cmd.rd, o_cmd.wr)
endmodule

// File: design/zlr_datapath.sv
// Bresenham walker, depth interpolator, divider and depth store.
`include "zbuffered_line_rasterizer_defines.svh"
module zlr_datapath #(
    parameter int TILE_WIDTH = 64,
    parameter int TILE_HEIGHT = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  zlr_pkg::t_cmd                         i_cmd,
    output zlr_pkg::t_sts                         o_sts,
    input  logic                                  i_cfg_we,
    input  logic signed [zlr_pkg::DEPTH_W-1:0]    i_cfg_data,
    output logic signed [zlr_pkg::DEPTH_W-1:0]    o_clear_depth,
    input  logic [zlr_pkg::COORD_W-1:0]           i_start_x,
    input  logic [zlr_pkg::COORD_W-1:0]           i_start_y,
    input  logic [zlr_pkg::COORD_W-1:0]           i_end_x,
    input  logic [zlr_pkg::COORD_W-1:0]           i_end_y,
    input  logic signed [zlr_pkg::DEPTH_W-1:0]    i_start_depth,
    input  logic signed [zlr_pkg::DEPTH_W-1:0]    i_end_depth,
    input  logic [zlr_pkg::COLOR_W-1:0]           i_line_color,
    input  logic signed [zlr_pkg::SHADE_W-1:0]    i_shade,
    output logic [zlr_pkg::COORD_W-1:0]           o_pixel_x,
    output logic [zlr_pkg::COORD_W-1:0]           o_pixel_y,
    output logic signed [zlr_pkg::DEPTH_W-1:0]    o_pixel_depth,
    output logic [zlr_pkg::COLOR_W-1:0]           o_pixel_color,
    output logic signed [zlr_pkg::SHADE_W-1:0]    o_pixel_shade,
    output logic                                  o_pixel_drawn,
    output logic                                  o_last_pixel
);
    import zlr_pkg::*;
    localparam int STORE = TILE_WIDTH * TILE_HEIGHT;
    localparam int AW = $clog2(STORE);

    logic signed [DEPTH_W-1:0] r_clear_depth;
    logic [COORD_W-1:0] r_col, r_row;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic r_sx_neg, r_sy_neg, r_xmaj;
    logic signed [COORD_W+2:0] r_err;
    logic signed [ACC_W-1:0] r_acc, r_inc;
    logic [COORD_W:0] r_left;
    logic signed [DEPTH_W-1:0] r_end_depth;
    logic [COLOR_W-1:0] r_color;
    logic signed [SHADE_W-1:0] r_shade;
    logic [COORD_W-1:0] r_steps;
    // restoring divider on magnitudes
    logic [DIFF_W-1:0] r_quo;
    logic [COORD_W:0] r_rem;
    logic r_neg;
    logic [5:0] r_div_cnt;
    logic [AW-1:0] r_clr_addr;
    logic signed [DEPTH_W-1:0] r_mem [STORE];
    logic signed [DEPTH_W-1:0] r_rd;
    logic r_inside;
    logic [AW-1:0] r_addr;

    logic [COORD_W:0] w_dx_s, w_dy_s;
    logic [COORD_W-1:0] w_adx, w_ady, w_steps;
    logic signed [DIFF_W-1:0] w_diff;
    logic [COORD_W+1:0] w_trial;
    logic signed [DEPTH_W-1:0] w_depth;

    always_comb begin
        w_dx_s = {1'b0, i_end_x} - {1'b0, i_start_x};
        w_dy_s = {1'b0, i_end_y} - {1'b0, i_start_y};
        w_adx = w_dx_s[COORD_W] ? COORD_W'(-w_dx_s) : w_dx_s[COORD_W-1:0];
        w_ady = w_dy_s[COORD_W] ? COORD_W'(-w_dy_s) : w_dy_s[COORD_W-1:0];
        w_steps = (w_adx >= w_ady) ? w_adx : w_ady;
        w_diff = DIFF_W'($signed({{1{i_end_depth[DEPTH_W-1]}}, i_end_depth}
                  - {{1{i_start_depth[DEPTH_W-1]}}, i_start_depth})) <<< FRAC_W;
        w_trial = {r_rem, r_quo[DIFF_W-1]} - {2'b00, r_steps};
        w_depth = (r_left == 1) ? r_end_depth : DEPTH_W'(r_acc >>> FRAC_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_depth <= CLEAR_DEPTH_RST;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) r_clear_depth <= i_cfg_data;
            if (i_cmd.clr_step) r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= i_start_x;
            r_row <= i_start_y;
            r_dx <= w_adx;
            r_dy <= w_ady;
            r_sx_neg <= w_dx_s[COORD_W];
            r_sy_neg <= w_dy_s[COORD_W];
            r_xmaj <= (w_adx >= w_ady);
            r_err <= (w_adx >= w_ady)
                ? ($signed({3'b0, w_ady} << 1) - $signed({3'b0, w_adx}))
                : ($signed({3'b0, w_adx} << 1) - $signed({3'b0, w_ady}));
            r_acc <= ACC_W'(i_start_depth) <<< FRAC_W;
            r_inc <= '0;
            r_left <= {1'b0, w_steps} + 1'b1;
            r_end_depth <= i_end_depth;
            r_color <= i_line_color;
            r_shade <= i_shade;
            r_steps <= w_steps;
            r_neg <= w_diff[DIFF_W-1];
            r_quo <= w_diff[DIFF_W-1] ? -w_diff : w_diff;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            if (!w_trial[COORD_W+1]) begin
                r_rem <= w_trial[COORD_W:0];
                r_quo <= {r_quo[DIFF_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[COORD_W-1:0], r_quo[DIFF_W-1]};
                r_quo <= {r_quo[DIFF_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_done) begin
            r_inc <= r_neg ? -ACC_W'({r_quo[DIFF_W-2:0], ~w_trial[COORD_W+1]})
                           : ACC_W'({r_quo[DIFF_W-2:0], ~w_trial[COORD_W+1]});
        end
        if (i_cmd.clr_step) r_mem[r_clr_addr] <= r_clear_depth;
        if (i_cmd.rd) begin
            r_inside <= (32'(r_col) < TILE_WIDTH) && (32'(r_row) < TILE_HEIGHT);
            r_addr <= AW'(r_row) * AW'(TILE_WIDTH) + AW'(r_col);
            r_rd <= r_mem[AW'(r_row) * AW'(TILE_WIDTH) + AW'(r_col)];
        end
        if (i_cmd.wr) begin
            o_pixel_x <= r_col;
            o_pixel_y <= r_row;
            o_pixel_depth <= w_depth;
            o_pixel_color <= r_color;
            o_pixel_shade <= r_shade;
            o_last_pixel <= (r_left == 1);
            o_pixel_drawn <= r_inside && (w_depth > r_rd);
            if (r_inside && (w_depth > r_rd)) r_mem[r_addr] <= w_depth;
            r_left <= r_left - 1'b1;
            r_acc <= r_acc + r_inc;
            if (r_xmaj) begin
                r_col <= r_sx_neg ? r_col - 1'b1 : r_col + 1'b1;
                if (r_err > 0) begin
                    r_row <= r_sy_neg ? r_row - 1'b1 : r_row + 1'b1;
                    r_err <= r_err + (($signed({3'b0, r_dy}) - $signed({3'b0, r_dx})) <<< 1);
                end else begin
                    r_err <= r_err + ($signed({3'b0, r_dy}) <<< 1);
                end
            end else begin
                r_row <= r_sy_neg ? r_row - 1'b1 : r_row + 1'b1;
                if (r_err > 0) begin
                    r_col <= r_sx_neg ? r_col - 1'b1 : r_col + 1'b1;
                    r_err <= r_err + (($signed({3'b0, r_dx}) - $signed({3'b0, r_dy})) <<< 1);
                end else begin
                    r_err <= r_err + ($signed({3'b0, r_dx}) <<< 1);
                end
            end
        end
    end

    assign o_sts.single = (r_steps == '0);
    assign o_sts.div_last = (r_div_cnt == 6'(DIFF_W - 1));
    assign o_sts.clr_last = (r_clr_addr == AW'(STORE - 1));
    assign o_sts.last_pix = (r_left == 1);
    assign o_clear_depth = r_clear_depth;

    `ZLR_ASSERT_IMPL(a_left_nz, i_clk, i_rst_n, i_cmd.wr, r_left != '0)
    `ZLR_ASSERT_NEXT(a_clr_wrap, i_clk, i_rst_n, i_cmd.clr_step && o_sts.clr_last, r_clr_addr == '0)
    `ZLR_ASSERT_IMPL(a_div_range, i_clk, i_rst_n, i_cmd.div_step, r_div_cnt < 6'(DIFF_W))
endmodule

// File: design/zbuffered_line_rasterizer.sv
// A segment of steps+1 pixels is accepted, then the divider computes the depth step (skipped
// for a single point), then each pixel takes a store read followed by a compare and write;
// a pixel's read waits while the previous pixel is still unaccepted at the output. The
// single-port depth store is why read and write are separate steps. A clear, at reset or by
// clear_first, sweeps all TILE_WIDTH*TILE_HEIGHT entries (4096 by default), one entry a cycle.
module zbuffered_line_rasterizer #(
    parameter int TILE_WIDTH = 64,
    parameter int TILE_HEIGHT = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [1:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [zlr_pkg::COORD_W-1:0]           i_start_x,
    input  logic [zlr_pkg::COORD_W-1:0]           i_start_y,
    input  logic [zlr_pkg::COORD_W-1:0]           i_end_x,
    input  logic [zlr_pkg::COORD_W-1:0]           i_end_y,
    input  logic signed [zlr_pkg::DEPTH_W-1:0]    i_start_depth,
    input  logic signed [zlr_pkg::DEPTH_W-1:0]    i_end_depth,
    input  logic [zlr_pkg::COLOR_W-1:0]           i_line_color,
    input  logic signed [zlr_pkg::SHADE_W-1:0]    i_shade,
    input  logic                                  i_clear_first,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [zlr_pkg::COORD_W-1:0]           o_pixel_x,
    output logic [zlr_pkg::COORD_W-1:0]           o_pixel_y,
    output logic signed [zlr_pkg::DEPTH_W-1:0]    o_pixel_depth,
    output logic [zlr_pkg::COLOR_W-1:0]           o_pixel_color,
    output logic signed [zlr_pkg::SHADE_W-1:0]    o_pixel_shade,
    output logic                                  o_pixel_drawn,
    output logic                                  o_last_pixel
);
    import zlr_pkg::*;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_cfg_we;
    logic signed [DEPTH_W-1:0] w_clear_depth;

    assign pready = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[1] == ADDR_CLEAR_DEPTH);
    assign prdata = (paddr[1] == ADDR_CLEAR_DEPTH)
        ? {{(32-DEPTH_W){w_clear_depth[DEPTH_W-1]}}, w_clear_depth} : '0;

    zlr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_clear_first(i_clear_first), .i_out_ready(i_ready), .i_sts(w_sts),
        .o_ready(o_ready), .o_out_valid(o_valid), .o_cmd(w_cmd)
    );

    zlr_datapath #(.TILE_WIDTH(TILE_WIDTH), .TILE_HEIGHT(TILE_HEIGHT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_we(w_cfg_we), .i_cfg_data(pwdata[DEPTH_W-1:0]),
        .o_clear_depth(w_clear_depth),
        .i_start_x(i_start_x), .i_start_y(i_start_y), .i_end_x(i_end_x),
        .i_end_y(i_end_y), .i_start_depth(i_start_depth), .i_end_depth(i_end_depth),
        .i_line_color(i_line_color), .i_shade(i_shade),
        .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y), .o_pixel_depth(o_pixel_depth),
        .o_pixel_color(o_pixel_color), .o_pixel_shade(o_pixel_shade),
        .o_pixel_drawn(o_pixel_drawn), .o_last_pixel(o_last_pixel)
    );
endmodule

// File: tb/tb_zbuffered_line_rasterizer.sv
// Self-checking testbench for the z-buffered line rasterizer.
`timescale 1ns / 1ps
module tb_zbuffered_line_rasterizer;
    import zlr_pkg::*;

    localparam int TW = 64;
    localparam int TH = 64;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam logic [1:0] REG_CLEAR_DEPTH = 2'd0;

    typedef struct {
        logic [COORD_W-1:0]        px;
        logic [COORD_W-1:0]        py;
        logic signed [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0]        color;
        logic signed [SHADE_W-1:0] shade;
        logic                      drawn;
        logic                      last;
    } t_pixel;

    typedef struct {
        logic [COORD_W-1:0]        x0, y0, x1, y1;
        logic signed [DEPTH_W-1:0] zs, ze;
        logic [COLOR_W-1:0]        color;
        logic signed [SHADE_W-1:0] shade;
        logic                      clr;
    } t_segment;

    int errors = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // Tracks depth store and pending pixels for each accepted segment.
    class raster_scoreboard;
        logic signed [DEPTH_W-1:0] depth_mem[TW*TH];
        logic signed [DEPTH_W-1:0] clear_val;
        t_pixel pending[$];
        int pixels_seen;

        function new();
            clear_val = CLEAR_DEPTH_RST;
            foreach (depth_mem[i]) depth_mem[i] = clear_val;
            pixels_seen = 0;
        endfunction

        function void set_clear(logic signed [DEPTH_W-1:0] v);
            clear_val = v;
        endfunction

        function void note_segment(t_segment s);
            int dx, dy, sx, sy, steps, dterm, col, row, n;
            bit xmaj;
            longint acc, inc, d;
            t_pixel p;
            if (s.clr) foreach (depth_mem[i]) depth_mem[i] = clear_val;
            dx = int'(s.x1) - int'(s.x0); sx = 1;
            if (dx < 0) begin dx = -dx; sx = -1; end
            dy = int'(s.y1) - int'(s.y0); sy = 1;
            if (dy < 0) begin dy = -dy; sy = -1; end
            xmaj = dx >= dy;
            steps = xmaj ? dx : dy;
            dterm = xmaj ? 2*dy - dx : 2*dx - dy;
            col = s.x0; row = s.y0;
            acc = longint'(s.zs) * 32768;
            inc = steps > 0 ? ((longint'(s.ze) - longint'(s.zs)) * 32768) / steps : 0;
            for (n = steps + 1; n > 0; n--) begin
                p.last = (n == 1);
                // floor, not truncation, for negative accumulators
                d = p.last ? longint'(s.ze) : (acc >>> 15);
                p.drawn = 0;
                if (col < TW && row < TH && d > longint'(depth_mem[row*TW+col])) begin
                    depth_mem[row*TW+col] = d[DEPTH_W-1:0];
                    p.drawn = 1;
                end
                p.px = col[COORD_W-1:0]; p.py = row[COORD_W-1:0];
                p.depth = d[DEPTH_W-1:0]; p.color = s.color; p.shade = s.shade;
                pending.push_back(p);
                if (n > 1) begin
                    if (xmaj) begin
                        col += sx;
                        if (dterm > 0) begin row += sy; dterm += 2*(dy-dx); end
                        else dterm += 2*dy;
                    end else begin
                        row += sy;
                        if (dterm > 0) begin col += sx; dterm += 2*(dx-dy); end
                        else dterm += 2*dx;
                    end
                    acc += inc;
                end
            end
        endfunction

        task check_pixel(t_pixel g);
            t_pixel w;
            pixels_seen++;
            if (pending.size() == 0) begin
                report("unexpected pixel", {g.px, g.py}, 0);
                return;
            end
            w = pending.pop_front();
            if (g.px != w.px) report("pixel_x", g.px, w.px);
            if (g.py != w.py) report("pixel_y", g.py, w.py);
            if (g.depth != w.depth) report("pixel_depth", g.depth, w.depth);
            if (g.color != w.color) report("pixel_color", g.color, w.color);
            if (g.shade != w.shade) report("pixel_shade", g.shade, w.shade);
            if (g.drawn != w.drawn) report("pixel_drawn", g.drawn, w.drawn);
            if (g.last != w.last) report("last_pixel", g.last, w.last);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;
    logic i_valid = 0, o_ready, o_valid, i_ready = 0;
    logic [COORD_W-1:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic signed [DEPTH_W-1:0] i_start_depth = '0, i_end_depth = '0;
    logic [COLOR_W-1:0] i_line_color = '0;
    logic signed [SHADE_W-1:0] i_shade = '0;
    logic i_clear_first = 0;
    logic [COORD_W-1:0] o_pixel_x, o_pixel_y;
    logic signed [DEPTH_W-1:0] o_pixel_depth;
    logic [COLOR_W-1:0] o_pixel_color;
    logic signed [SHADE_W-1:0] o_pixel_shade;
    logic o_pixel_drawn, o_last_pixel;

    always #4 i_clk = ~i_clk;

    zbuffered_line_rasterizer #(.TILE_WIDTH(TW), .TILE_HEIGHT(TH)) i_dut (.*);

    raster_scoreboard sb = new();
    int segs_sent = 0, idle_cycles = 0, stall_mode = 0;
    logic [7:0] stall_lfsr = 8'h5a;

    // Receiver: stall pattern changes phase every so often.
    always @(posedge i_clk) begin
        t_pixel g;
        stall_lfsr <= {stall_lfsr[6:0],
                       stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= stall_lfsr[0];
            2: i_ready <= stall_lfsr[2:0] == 3'b000;
            default: i_ready <= ($urandom_range(0, 9) != 0);
        endcase
        if (i_rst_n && o_valid && i_ready) begin
            g.px = o_pixel_x; g.py = o_pixel_y; g.depth = o_pixel_depth;
            g.color = o_pixel_color; g.shade = o_pixel_shade;
            g.drawn = o_pixel_drawn; g.last = o_last_pixel;
            sb.check_pixel(g);
        end
    end

    // Stall watchdog.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_clear_depth(input logic signed [DEPTH_W-1:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_CLEAR_DEPTH;
        pwdata <= {{(32-DEPTH_W){v[DEPTH_W-1]}}, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_clear(v);
    endtask

    task automatic send_segment(input t_segment s);
        @(posedge i_clk);
        i_valid <= 1;
        i_start_x <= s.x0; i_start_y <= s.y0; i_end_x <= s.x1; i_end_y <= s.y1;
        i_start_depth <= s.zs; i_end_depth <= s.ze; i_line_color <= s.color;
        i_shade <= s.shade; i_clear_first <= s.clr;
        do @(posedge i_clk); while (!o_ready);
        sb.note_segment(s);
        segs_sent++;
        i_valid <= 0;
    endtask

    function automatic t_segment make_seg(int x0, int y0, int x1, int y1, int zs, int ze,
                                          bit clr);
        t_segment s;
        s.x0 = COORD_W'(x0); s.y0 = COORD_W'(y0); s.x1 = COORD_W'(x1); s.y1 = COORD_W'(y1);
        s.zs = DEPTH_W'(zs); s.ze = DEPTH_W'(ze); s.clr = clr;
        s.color = COLOR_W'($urandom); s.shade = SHADE_W'($urandom);
        return s;
    endfunction

    function automatic t_segment rand_seg();
        t_segment s;
        int len;
        // mostly short lines; few full-tile sweeps
        len = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(0, 12);
        s.x0 = COORD_W'($urandom); s.y0 = COORD_W'($urandom);
        s.x1 = $urandom_range(0, 1) ? COORD_W'(s.x0 + $urandom_range(0, len))
                                    : COORD_W'(s.x0 - $urandom_range(0, len));
        s.y1 = $urandom_range(0, 1) ? COORD_W'(s.y0 + $urandom_range(0, len))
                                    : COORD_W'(s.y0 - $urandom_range(0, len));
        s.zs = DEPTH_W'($urandom); s.ze = DEPTH_W'($urandom);
        if ($urandom_range(0, 3) == 0) s.ze = s.zs;
        if ($urandom_range(0, 3) == 0) s.zs = DEPTH_W'($urandom_range(0, 2000) - 1000);
        s.color = COLOR_W'($urandom); s.shade = SHADE_W'($urandom);
        s.clr = ($urandom_range(0, 39) == 0);
        return s;
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic burst(input int count);
        int left;
        left = count;
        while (left > 0) begin
            int blen;
            blen = $urandom_range(1, 8);
            while (blen > 0 && left > 0) begin
                send_segment(rand_seg());
                blen--; left--;
            end
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: octants, axes, diagonals, single point, edges, ties
        send_segment(make_seg(5, 5, 5, 5, 100, -100, 0));
        send_segment(make_seg(0, 0, 63, 0, -8388608, 8388607, 0));
        send_segment(make_seg(63, 63, 0, 63, 8388607, -8388608, 0));
        send_segment(make_seg(0, 0, 0, 63, 1000, 1000, 0));
        send_segment(make_seg(0, 63, 63, 0, -5, 7, 0));
        send_segment(make_seg(63, 0, 0, 63, 300, -300, 0));
        send_segment(make_seg(10, 10, 20, 15, 50, 60, 0));
        send_segment(make_seg(10, 10, 15, 20, 50, 60, 0));
        send_segment(make_seg(20, 20, 10, 25, -50, 60, 0));
        send_segment(make_seg(20, 20, 25, 10, 50, -60, 0));
        send_segment(make_seg(20, 20, 10, 15, 1, 2, 0));
        send_segment(make_seg(20, 20, 15, 10, 2, 1, 0));
        send_segment(make_seg(30, 30, 40, 31, 0, 10, 0));
        send_segment(make_seg(30, 30, 40, 31, 0, 10, 0));  // equal depth: not drawn
        send_segment(make_seg(30, 30, 40, 31, 0, 10, 1));  // clear then redraw
        send_segment(make_seg(1, 2, 7, 5, -2560001, -2560000, 1));
        send_segment(make_seg(63, 63, 63, 63, 8388607, 8388607, 0));
        drain();
        write_clear_depth(24'sh7FFFFF);
        send_segment(make_seg(3, 3, 9, 9, 8388607, 8388607, 1));
        drain();
        write_clear_depth(-24'sd8388608);
        send_segment(make_seg(3, 3, 9, 9, -8388607, -8388608, 1));
        burst(130);
        drain();
        write_clear_depth(DEPTH_W'($urandom));
        burst(130);
        drain();
        write_clear_depth(CLEAR_DEPTH_RST);
        burst(130);
        drain();
        $display("Covered %0d segments and %0d pixels over four clear-depth settings.",
                 segs_sent, sb.pixels_seen);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
